// ===== src/chpr_pkg.sv =====
package chpr_pkg;

	// Request codes.
	localparam logic [1:0] REQ_OPEN    = 2'd0;
	localparam logic [1:0] REQ_CLOSE   = 2'd1;
	localparam logic [1:0] REQ_QUERY   = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// One channel table entry, 43 bits.
	typedef struct packed {
		logic        is_open;
		logic        rx_en;
		logic        tx_en;
		logic [7:0]  tag_lo;
		logic [7:0]  tag_hi;
		logic [7:0]  tag_ctrl;
		logic [15:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/channel_pair_registry_unit.sv =====
// Channel pair registry: a table of one-way channel entries, one per source and
// destination cluster pair, held in a single RAM with one read and one write port.
// After reset the unit clears all CLUSTERS*CLUSTERS entries, one entry a cycle,
// and holds in_stall high until the pass is done. Requests are then handled one at
// a time: an open or close request is accepted with the table read, then checked
// and written back; a query reads its forward and then its reverse entry through
// the one read port before it checks both. An unknown request is accepted and
// dropped without a result. The result sits in an output register, so a new request
// is taken while the previous result is still stalled; a request only waits at its
// last step if the output register still holds a stalled result.
module channel_pair_registry_unit
	import chpr_pkg::*;
#(
	parameter int CLUSTERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  src_id,
	input  logic [3:0]  dst_id,
	input  logic        rx_enable,
	input  logic        tx_enable,
	input  logic [7:0]  min_rx_tag,
	input  logic [7:0]  max_rx_tag,
	input  logic [15:0] rx_mtu,
	input  logic [7:0]  ctrl_rx_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        is_closed,
	output logic        access_denied,
	output logic [15:0] path_mtu,
	output logic [7:0]  peer_min_rx,
	output logic [7:0]  peer_max_rx,
	output logic [7:0]  peer_ctrl_rx
);

	localparam int DEPTH = CLUSTERS * CLUSTERS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RD1   = 2'd2;
	localparam logic [1:0] ST_RD2   = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;

	logic [1:0]    req_q;
	logic [3:0]    src_q;
	logic [3:0]    dst_q;
	logic          rng_q;
	logic [AW-1:0] fwd_addr_q;
	entry_t        new_entry_q;
	entry_t        fwd_q;

	logic          out_valid_q;
	logic          status_q;
	logic          is_closed_q;
	logic          access_denied_q;
	logic [15:0]   path_mtu_q;
	logic [7:0]    peer_min_q;
	logic [7:0]    peer_max_q;
	logic [7:0]    peer_ctrl_q;

	logic          in_acc;
	logic          out_free;
	logic          in_rng;
	logic [AW-1:0] in_addr;
	logic [AW-1:0] back_addr;

	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	entry_t        ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	entry_t        ram_rd_data;

	logic          finish;
	logic          res_status;
	logic          res_closed;
	logic          res_denied;
	logic [15:0]   res_mtu;
	logic [7:0]    res_min;
	logic [7:0]    res_max;
	logic [7:0]    res_ctrl;

	// Handshake and address formation.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_rng    = (int'(src_id) < CLUSTERS) && (int'(dst_id) < CLUSTERS);
	assign in_addr   = AW'(int'(src_id) * CLUSTERS + int'(dst_id));
	assign back_addr = AW'(int'(dst_q) * CLUSTERS + int'(src_q));

	// Result and table write of the request in its last cycle, and the clearing writes; rd_data holds the entry read last.
	always_comb begin
		finish     = 1'b0;
		res_status = 1'b0;
		res_closed = 1'b0;
		res_denied = 1'b0;
		res_mtu    = '0;
		res_min    = '0;
		res_max    = '0;
		res_ctrl   = '0;
		ram_wr_en  = 1'b0;
		ram_wr_data = '0;
		ram_wr_addr = fwd_addr_q;
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_q;
		end else if (state_q == ST_RD1 && req_q != REQ_QUERY) begin
			finish = out_free;
			if (req_q == REQ_OPEN) begin
				res_status  = !rng_q || ram_rd_data.is_open;
				ram_wr_data = new_entry_q;
			end else begin
				res_status  = !rng_q || !ram_rd_data.is_open;
			end
			ram_wr_en = finish && !res_status;
		end else if (state_q == ST_RD2) begin
			finish = out_free;
			if (!rng_q || !fwd_q.is_open || !ram_rd_data.is_open) begin
				res_status = 1'b1;
				res_closed = 1'b1;
			end else if (!fwd_q.tx_en || !ram_rd_data.rx_en) begin
				res_status = 1'b1;
				res_denied = 1'b1;
			end else begin
				res_mtu  = (fwd_q.size < ram_rd_data.size) ? fwd_q.size : ram_rd_data.size;
				res_min  = ram_rd_data.tag_lo;
				res_max  = ram_rd_data.tag_hi;
				res_ctrl = ram_rd_data.tag_ctrl;
			end
		end
	end

	// Read port: forward entry on accept, reverse entry for a query.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = in_addr;
		if (in_acc) begin
			ram_rd_en = 1'b1;
		end else if (state_q == ST_RD1 && req_q == REQ_QUERY) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = back_addr;
		end
	end

	// Sequencer and clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && req_type != REQ_UNKNOWN) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					if (req_q == REQ_QUERY) begin
						state_q <= ST_RD2;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD2: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Request capture and forward entry capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q       <= req_type;
			src_q       <= src_id;
			dst_q       <= dst_id;
			rng_q       <= in_rng;
			fwd_addr_q  <= in_addr;
			new_entry_q <= '{is_open: 1'b1, rx_en: rx_enable, tx_en: tx_enable,
				tag_lo: min_rx_tag, tag_hi: max_rx_tag, tag_ctrl: ctrl_rx_tag,
				size: rx_mtu};
		end
		if (state_q == ST_RD1) begin
			fwd_q <= ram_rd_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q        <= res_status;
			is_closed_q     <= res_closed;
			access_denied_q <= res_denied;
			path_mtu_q      <= res_mtu;
			peer_min_q      <= res_min;
			peer_max_q      <= res_max;
			peer_ctrl_q     <= res_ctrl;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign is_closed     = is_closed_q;
	assign access_denied = access_denied_q;
	assign path_mtu      = path_mtu_q;
	assign peer_min_rx   = peer_min_q;
	assign peer_max_rx   = peer_max_q;
	assign peer_ctrl_rx  = peer_ctrl_q;

	chpr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// A table write outside the clearing pass belongs to a successful open or close.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && state_q != ST_CLEAR) |->
			(state_q == ST_RD1 && (req_q == REQ_OPEN || req_q == REQ_CLOSE) && !res_status))
		else $error("table written outside an open or close");

	// A new result is only produced at the end of a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RD1 || $past(state_q) == ST_RD2))
		else $error("result appeared without a request finishing");

	// A successful result carries no failure flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !status_q) |-> (!is_closed_q && !access_denied_q))
		else $error("success reported with a failure flag");

	// Closed and access denied exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(is_closed_q && access_denied_q))
		else $error("closed and access denied both set");

endmodule

// ===== src/chpr_ram.sv =====
module chpr_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
